// ===== hw/rtl/mpbae_pkg.sv =====
// Shared types and constants of the MED predictor and binary arithmetic encoder.
package mpbae_pkg;

  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned SVAL_W      = 9;
  localparam int unsigned ROW_W       = NUM_CH * SVAL_W;
  localparam int unsigned PROB_W      = 16;
  localparam int unsigned PROB_DEPTH  = 768;
  localparam int unsigned PROB_AW     = $clog2(PROB_DEPTH);
  localparam int unsigned ADAPT_SHIFT = 7;

  localparam logic [PROB_W-1:0]  PROB_INIT    = 16'h8000;
  localparam logic [PROB_W:0]    ADAPT_ONE    = 17'd65600;  // 65536 plus rounding
  localparam logic [PROB_W:0]    ADAPT_ZERO   = 17'd63;
  localparam logic [12:0]        WIDTH_RESET  = 13'd640;
  localparam logic [2:0]         FLUSH_BYTES  = 3'd4;
  localparam logic               CMD_PIXEL    = 1'b0;
  localparam logic               CMD_FLUSH    = 1'b1;

  typedef logic signed [SVAL_W-1:0] sval_t;
  typedef logic [NUM_CH-1:0][SVAL_W-1:0] spix_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROWRD,
    ST_CHAN,
    ST_FETCH,
    ST_RENORM,
    ST_EMIT,
    ST_MUL,
    ST_UPD,
    ST_WRAP,
    ST_FLUSH
  } state_e;

endpackage

// ===== hw/rtl/mpbae_if.sv =====
// Valid/ready channel interfaces for pixel input beats and coded byte output beats.
interface mpbae_pix_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, cmd, red, green, blue, input ready);
  modport sink   (input valid, cmd, red, green, blue, output ready);
endinterface

interface mpbae_code_if;
  logic        valid;
  logic        ready;
  logic [31:0] coded_bytes;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, coded_bytes, byte_count, last, input ready);
  modport sink   (input valid, coded_bytes, byte_count, last, output ready);
endinterface

// ===== hw/rtl/mpbae_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module mpbae_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read strobe.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/med_predict_binary_arith_encoder_core.sv =====
// Top level of the lossless RGB encoder: MED prediction and adaptive binary arithmetic coding.
//
// Each pixel beat (cmd = 0) is split into green-128, blue-128 and red-128; chroma is stored
// relative to green, predicted by the median of N, W and N+W-NW (zero outside the image),
// and the 8-bit residual is coded MSB first through a 255-node context tree per channel.
// A flush beat (cmd = 1) emits the four bytes of the coder's low bound with last = 1 and
// restarts the coder; pixel history and probabilities are kept. One sequencer drives a
// single 32x16 multiplier and one range adder for all 24 coding steps of a pixel. Each
// coded bit takes a probability read, a renormalize check, a multiply and a range update;
// each channel first latches its residual, and each pixel adds the accept, row fetch and
// write-back. Each emitted byte adds a renormalize step and each output beat an emit step
// (at most 24 beats), and the pixel runs longer while the output side stalls. After reset
// the block runs a clearing pass over all 768 probability entries before it accepts a
// beat; the image width register may be written at any time meanwhile. The row store needs
// no clearing: a fill count marks the columns written so far, and unwritten ones read zero.
// The output register lets one coded beat wait while coding continues to the next emit.
module med_predict_binary_arith_encoder_core #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [12:0]        cfg_wdata_i,
  mpbae_pix_if.sink          pix_i,
  mpbae_code_if.source       code_o
);

  import mpbae_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam logic [31:0] MaxW32 = 32'(MAX_WIDTH);

  state_e state_q, state_d;

  // Configuration and coder state.
  logic [12:0]         width_q, width_d;
  logic [31:0]         low_q, low_d;
  logic [31:0]         high_q, high_d;
  logic [CW-1:0]       column_q, column_d;
  logic [CW:0]         fill_q, fill_d;
  spix_t               left_q, left_d;
  spix_t               upleft_q, upleft_d;

  // Sequencer counters.
  logic [PROB_AW-1:0]  clr_q, clr_d;
  logic [1:0]          kc_q, kc_d;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          tidx_q, tidx_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [31:0]         bytes_q, bytes_d;

  // Payload registers.
  logic [NUM_CH-1:0][7:0] px_q;
  logic [7:0]          err_q;
  spix_t               cur_q;
  spix_t               npix_q;
  logic [31:0]         prod_q;

  // Output register.
  logic                ov_q, ov_d;
  logic [31:0]         obytes_q;
  logic [2:0]          ocnt_q;
  logic                olast_q;
  logic                oload;
  logic [31:0]         oload_bytes;
  logic [2:0]          oload_cnt;
  logic                oload_last;
  logic                slot_free;

  // Memory ports.
  logic                row_we, row_re;
  logic [ROW_W-1:0]    row_rdata;
  logic                prob_we, prob_re;
  logic [PROB_AW-1:0]  prob_waddr;
  logic [PROB_AW-1:0]  prob_raddr;
  logic [PROB_W-1:0]   prob_wdata;
  logic [PROB_W-1:0]   prob_rdata;

  mpbae_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (column_q),
    .wdata_i (cur_q),
    .re_i    (row_re),
    .raddr_i (column_q),
    .rdata_o (row_rdata)
  );

  mpbae_ram #(
    .WIDTH (PROB_W),
    .DEPTH (PROB_DEPTH)
  ) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (prob_we),
    .waddr_i (prob_waddr),
    .wdata_i (prob_wdata),
    .re_i    (prob_re),
    .raddr_i (prob_raddr),
    .rdata_o (prob_rdata)
  );

  // Effective width: zero counts as one, anything above the row store depth clamps.
  logic [31:0] cfg_w32;
  logic [31:0] eff_w32;
  logic [CW:0] eff_w;
  logic [CW:0] col_next;
  logic        row_wrap;

  assign cfg_w32  = 32'(width_q);
  assign eff_w32  = (cfg_w32 == 32'd0) ? 32'd1 : ((cfg_w32 > MaxW32) ? MaxW32 : cfg_w32);
  assign eff_w    = eff_w32[CW:0];
  assign col_next = {1'b0, column_q} + {{CW{1'b0}}, 1'b1};
  assign row_wrap = (col_next >= eff_w);

  // Row above: columns beyond the fill count were never written and read as zero.
  spix_t n_pix;
  assign n_pix = ({1'b0, column_q} < fill_q) ? spix_t'(row_rdata) : '0;

  // Prediction for the channel under kc_q.
  logic signed [7:0]  ch_s, ch0_s, pred8;
  sval_t              n_s, w_s, nw_s, off_s, lo_s, hi_s, cur_s;
  logic signed [10:0] c_s, med_s, pred_s;
  logic [7:0]         err_c;

  always_comb begin
    ch_s   = $signed({~px_q[kc_q][7], px_q[kc_q][6:0]});
    ch0_s  = $signed({~px_q[0][7], px_q[0][6:0]});
    n_s    = $signed(n_pix[kc_q]);
    w_s    = $signed(left_q[kc_q]);
    nw_s   = $signed(upleft_q[kc_q]);
    off_s  = (kc_q == 2'd0) ? '0 : $signed({ch0_s[7], ch0_s});
    lo_s   = (n_s < w_s) ? n_s : w_s;
    hi_s   = (n_s < w_s) ? w_s : n_s;
    c_s    = 11'(n_s) + 11'(w_s) - 11'(nw_s);
    if (c_s < 11'(lo_s)) begin
      med_s = 11'(lo_s);
    end else if (c_s > 11'(hi_s)) begin
      med_s = 11'(hi_s);
    end else begin
      med_s = c_s;
    end
    pred_s = med_s + 11'(off_s);
    if (pred_s < -11'sd128) begin
      pred8 = -8'sd128;
    end else if (pred_s > 11'sd127) begin
      pred8 = 8'sd127;
    end else begin
      pred8 = $signed(pred_s[7:0]);
    end
    err_c  = 8'(ch_s - pred8);
    cur_s  = $signed({ch_s[7], ch_s}) - off_s;
  end

  // Shared coder unit: one multiply, then one range add.
  logic [47:0]       product;
  logic [31:0]       mid;
  logic              cur_bit;
  logic [PROB_W-1:0] p_new;
  logic [PROB_W:0]   up_one, up_zero;
  logic              renorm_need;

  assign product     = (high_q - low_q) * prob_rdata;
  assign mid         = low_q + prod_q;
  assign cur_bit     = err_q[bit_q];
  assign up_one      = (ADAPT_ONE - {1'b0, prob_rdata}) >> ADAPT_SHIFT;
  assign up_zero     = ({1'b0, prob_rdata} + ADAPT_ZERO) >> ADAPT_SHIFT;
  assign p_new       = cur_bit ? (prob_rdata + up_one[PROB_W-1:0])
                               : (prob_rdata - up_zero[PROB_W-1:0]);
  assign renorm_need = ((low_q[31:24] ^ high_q[31:24]) == 8'd0);
  assign slot_free   = !ov_q || code_o.ready;

  always_comb begin
    state_d     = state_q;
    width_d     = cfg_we_i ? cfg_wdata_i : width_q;
    low_d       = low_q;
    high_d      = high_q;
    column_d    = column_q;
    fill_d      = fill_q;
    left_d      = left_q;
    upleft_d    = upleft_q;
    clr_d       = clr_q;
    kc_d        = kc_q;
    bit_d       = bit_q;
    tidx_d      = tidx_q;
    cnt_d       = cnt_q;
    bytes_d     = bytes_q;
    oload       = 1'b0;
    oload_bytes = bytes_q;
    oload_cnt   = cnt_q;
    oload_last  = 1'b0;
    row_we      = 1'b0;
    row_re      = 1'b0;
    prob_we     = 1'b0;
    prob_re     = 1'b0;
    prob_waddr  = {kc_q, tidx_q};
    prob_raddr  = {kc_q, tidx_q};
    prob_wdata  = p_new;
    pix_i.ready = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // Sweep the probability memory back to one half.
        prob_we    = 1'b1;
        prob_waddr = clr_q;
        prob_wdata = PROB_INIT;
        if (clr_q == PROB_AW'(PROB_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        pix_i.ready = 1'b1;
        if (pix_i.valid) begin
          state_d = (pix_i.cmd == CMD_FLUSH) ? ST_FLUSH : ST_ROWRD;
        end
      end
      ST_ROWRD: begin
        row_re  = 1'b1;
        kc_d    = 2'd0;
        state_d = ST_CHAN;
      end
      ST_CHAN: begin
        // Start a channel: residual is latched, tree walk restarts at the root.
        bit_d   = 3'd7;
        tidx_d  = 8'd1;
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        prob_re = 1'b1;
        cnt_d   = 3'd0;
        bytes_d = '0;
        state_d = ST_RENORM;
      end
      ST_RENORM: begin
        if (renorm_need) begin
          bytes_d = {bytes_q[23:0], low_q[31:24]};
          cnt_d   = cnt_q + 1'b1;
          low_d   = {low_q[23:0], 8'h00};
          high_d  = {high_q[23:0], 8'hFF};
        end else if (cnt_q != 3'd0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        // Hold until the output register frees up.
        if (slot_free) begin
          oload   = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        prob_we = 1'b1;
        if (cur_bit) begin
          high_d = mid;
        end else begin
          low_d = mid + 32'd1;
        end
        tidx_d = {tidx_q[6:0], cur_bit};
        if (bit_q != 3'd0) begin
          bit_d   = bit_q - 1'b1;
          state_d = ST_FETCH;
        end else if (kc_q == 2'(NUM_CH - 1)) begin
          state_d = ST_WRAP;
        end else begin
          kc_d    = kc_q + 1'b1;
          state_d = ST_CHAN;
        end
      end
      ST_WRAP: begin
        // Write back the row, advance the column, and drop history at row end.
        row_we = 1'b1;
        if ({1'b0, column_q} >= fill_q) begin
          fill_d = col_next;
        end
        if (row_wrap) begin
          column_d = '0;
          left_d   = '0;
          upleft_d = '0;
        end else begin
          column_d = col_next[CW-1:0];
          left_d   = cur_q;
          upleft_d = npix_q;
        end
        state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (slot_free) begin
          oload       = 1'b1;
          oload_bytes = low_q;
          oload_cnt   = FLUSH_BYTES;
          oload_last  = 1'b1;
          low_d       = '0;
          high_d      = '1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (oload) begin
      ov_d = 1'b1;
    end else if (code_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      width_q  <= WIDTH_RESET;
      low_q    <= '0;
      high_q   <= '1;
      column_q <= '0;
      fill_q   <= '0;
      left_q   <= '0;
      upleft_q <= '0;
      clr_q    <= '0;
      kc_q     <= '0;
      bit_q    <= '0;
      tidx_q   <= '0;
      cnt_q    <= '0;
      bytes_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      width_q  <= width_d;
      low_q    <= low_d;
      high_q   <= high_d;
      column_q <= column_d;
      fill_q   <= fill_d;
      left_q   <= left_d;
      upleft_q <= upleft_d;
      clr_q    <= clr_d;
      kc_q     <= kc_d;
      bit_q    <= bit_d;
      tidx_q   <= tidx_d;
      cnt_q    <= cnt_d;
      bytes_q  <= bytes_d;
      ov_q     <= ov_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pix_i.valid && pix_i.cmd == CMD_PIXEL) begin
      px_q[0] <= pix_i.green;
      px_q[1] <= pix_i.blue;
      px_q[2] <= pix_i.red;
    end
    if (state_q == ST_CHAN) begin
      err_q        <= err_c;
      cur_q[kc_q]  <= cur_s;
      if (kc_q == 2'd0) begin
        npix_q <= n_pix;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= product[47:16];
    end
    if (oload) begin
      obytes_q <= oload_bytes;
      ocnt_q   <= oload_cnt;
      olast_q  <= oload_last;
    end
  end

  assign code_o.valid       = ov_q;
  assign code_o.coded_bytes = obytes_q;
  assign code_o.byte_count  = ocnt_q;
  assign code_o.last        = olast_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the MED predictor and adaptive binary arithmetic encoder core.
module tb_top;
  import mpbae_pkg::*;

  localparam int MAX_W         = 4096;
  localparam int SETTLE_CYCLES = 200;  // worst pixel with no output beat, plus margin

  // One pixel-side beat and one coded-side beat as the bench keeps them.
  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_beat_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  count;
    logic        last;
  } code_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [12:0] cfg_wdata_i;

  mpbae_pix_if  pix_if ();
  mpbae_code_if code_if ();

  med_predict_binary_arith_encoder_core #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix_if),
    .code_o     (code_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Beats waiting to be offered, and coded beats the encoder still owes us.
  pix_beat_t  pix_pending [$];
  code_beat_t beats_due [$];

  // Idle pressure of the current phase, in percent per cycle.
  int src_gap_pct;
  int sink_stall_pct;

  int mismatches;
  int n_pixels;
  int n_flushes;
  int n_beats;
  int n_widths;

  // ---------------------------------------------------------------------------
  // Encoder shadow: its own copy of pixel history, context tree and coder range.
  // ---------------------------------------------------------------------------
  sval_t             row_mem [MAX_W][NUM_CH];
  logic [PROB_W-1:0] ctx_prob [PROB_DEPTH];
  logic [31:0]       span_lo;
  logic [31:0]       span_hi;
  int                col_pos;
  sval_t             west_px [NUM_CH];
  sval_t             nwest_px [NUM_CH];
  logic [12:0]       width_cfg;

  function automatic void shadow_reset();
    for (int c = 0; c < MAX_W; c++)
      for (int k = 0; k < NUM_CH; k++) row_mem[c][k] = '0;
    for (int i = 0; i < PROB_DEPTH; i++) ctx_prob[i] = PROB_INIT;
    span_lo   = '0;
    span_hi   = '1;
    col_pos   = 0;
    width_cfg = WIDTH_RESET;
    for (int k = 0; k < NUM_CH; k++) begin
      west_px[k]  = '0;
      nwest_px[k] = '0;
    end
  endfunction

  // Flush: hand out the low bound whole and restart the coder range.
  function automatic void flush_coder();
    beats_due.push_back('{bytes: span_lo, count: FLUSH_BYTES, last: 1'b1});
    span_lo = '0;
    span_hi = '1;
  endfunction

  // Predict, take the residual and code its 8 bits, queueing every renormalization burst.
  function automatic void code_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int          comp [NUM_CH];
    int          north [NUM_CH];
    int          keep [NUM_CH];
    int          eff_w, col, ofs, wv, nwv, grad, lo_v, hi_v, pr, node, pidx, t, nb;
    logic [7:0]  resid;
    logic [31:0] emit, mid;
    logic [15:0] p;
    logic        bitv;
    // channel order is green, blue, red
    comp[0] = int'(g) - 128;
    comp[1] = int'(b) - 128;
    comp[2] = int'(r) - 128;
    eff_w = (width_cfg == 0) ? 1 : ((int'(width_cfg) > MAX_W) ? MAX_W : int'(width_cfg));
    col   = (col_pos < MAX_W) ? col_pos : 0;
    for (int k = 0; k < NUM_CH; k++) north[k] = row_mem[col][k];

    for (int k = 0; k < NUM_CH; k++) begin
      ofs  = (k == 0) ? 0 : comp[0];
      wv   = west_px[k];
      nwv  = nwest_px[k];
      grad = north[k] + wv - nwv;
      lo_v = (north[k] < wv) ? north[k] : wv;
      hi_v = (north[k] < wv) ? wv : north[k];
      pr   = (grad < lo_v) ? lo_v : ((grad > hi_v) ? hi_v : grad);
      pr   = pr + ofs;
      if (pr < -128) pr = -128;
      if (pr > 127) pr = 127;
      resid   = 8'(comp[k] - pr);
      keep[k] = comp[k] - ofs;
      node    = 1;

      for (int kb = 7; kb >= 0; kb--) begin
        bitv = resid[kb];
        pidx = k * 256 + (node & 255);
        p    = ctx_prob[pidx];
        emit = '0;
        nb   = 0;
        // shift out settled top bytes before the split
        while ((span_lo ^ span_hi) < 32'h0100_0000) begin
          emit    = {emit[23:0], span_lo[31:24]};
          nb++;
          span_lo = span_lo << 8;
          span_hi = {span_hi[23:0], 8'hFF};
        end
        if (nb != 0) beats_due.push_back('{bytes: emit, count: 3'(nb), last: 1'b0});
        mid = span_lo + 32'((64'(span_hi - span_lo) * 64'(p)) >> 16);
        if (bitv) span_hi = mid;
        else      span_lo = mid + 32'd1;
        // adapt toward the coded bit, rounding to nearest
        t = (bitv ? 65600 : 64) - int'(p);
        ctx_prob[pidx] = 16'(int'(p) + (t >>> 7));
        node = node * 2 + int'(bitv);
      end
    end

    for (int k = 0; k < NUM_CH; k++) begin
      row_mem[col][k] = sval_t'(keep[k]);
      nwest_px[k]     = sval_t'(north[k]);
      west_px[k]      = sval_t'(keep[k]);
    end
    if (col + 1 >= eff_w) begin
      col_pos = 0;
      for (int k = 0; k < NUM_CH; k++) begin
        west_px[k]  = '0;
        nwest_px[k] = '0;
      end
    end else begin
      col_pos = col + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: model each accepted pixel or flush beat, then offer the next one or idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pix_beat_t nxt;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        if (pix_if.cmd == CMD_FLUSH) begin
          flush_coder();
          n_flushes++;
        end else begin
          code_pixel(pix_if.red, pix_if.green, pix_if.blue);
          n_pixels++;
        end
      end
      // the slot is free once the held beat went through or nothing was held
      if (!pix_if.valid || pix_if.ready) begin
        if (pix_pending.size() > 0 && $urandom_range(99) >= src_gap_pct) begin
          nxt = pix_pending.pop_front();
          pix_if.valid <= 1'b1;
          pix_if.cmd   <= nxt.cmd;
          pix_if.red   <= nxt.red;
          pix_if.green <= nxt.green;
          pix_if.blue  <= nxt.blue;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Coded-beat monitor: compare against the oldest owed beat, then pick next ready.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    code_beat_t want;
    if (rst_ni) begin
      if (code_if.valid && code_if.ready) begin
        n_beats++;
        if (beats_due.size() == 0) begin
          $error("coded beat with none owed: coded_bytes %h byte_count %0d last %0b",
                 code_if.coded_bytes, code_if.byte_count, code_if.last);
          mismatches++;
        end else begin
          want = beats_due.pop_front();
          check_field("coded_bytes", want.bytes, code_if.coded_bytes);
          check_field("byte_count", 32'(want.count), 32'(code_if.byte_count));
          check_field("last", 32'(want.last), 32'(code_if.last));
        end
      end
      code_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_pending.push_back('{cmd: CMD_PIXEL, red: r, green: g, blue: b});
  endfunction

  function automatic void push_flush();
    pix_pending.push_back('{cmd: CMD_FLUSH, red: 8'($urandom), green: 8'($urandom),
                            blue: 8'($urandom)});
  endfunction

  // Hold until every beat is offered and taken and nothing is owed, then let the
  // core finish a pixel that produced no coded beat.
  task automatic settle();
    while (pix_pending.size() != 0 || pix_if.valid || beats_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the image width only with the core idle; the shadow follows at once.
  task automatic set_width(logic [12:0] w);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_cfg = w;
    n_widths++;
  endtask

  // One image fragment: mostly smooth runs so the contexts skew and the coder
  // goes long between bytes, mixed with noise, saturated pixels and stray flushes.
  task automatic queue_image(int n_items);
    logic [7:0] r, g, b;
    int kind;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    for (int i = 0; i < n_items; i++) begin
      kind = $urandom_range(99);
      if (kind < 5) begin
        push_flush();
      end else begin
        if (kind < 15) begin
          r = $urandom_range(1) ? 8'hFF : 8'h00;
          g = $urandom_range(1) ? 8'hFF : 8'h00;
          b = $urandom_range(1) ? 8'hFF : 8'h00;
        end else if (kind < 40) begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end else begin
          r = r + 8'($urandom_range(6)) - 8'd3;
          g = g + 8'($urandom_range(6)) - 8'd3;
          b = b + 8'($urandom_range(6)) - 8'd3;
        end
        push_pixel(r, g, b);
      end
    end
    push_flush();
  endtask

  task automatic run_phase(int src_pct, int sink_pct, logic [12:0] w, int n_items);
    set_width(w);
    src_gap_pct    = src_pct;
    sink_stall_pct = sink_pct;
    queue_image(n_items);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    pix_if.valid    = 1'b0;
    pix_if.cmd      = CMD_PIXEL;
    pix_if.red      = '0;
    pix_if.green    = '0;
    pix_if.blue     = '0;
    code_if.ready   = 1'b0;
    src_gap_pct     = 0;
    sink_stall_pct  = 0;
    mismatches      = 0;
    n_pixels        = 0;
    n_flushes       = 0;
    n_beats         = 0;
    n_widths        = 0;
    shadow_reset();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: four-wide rows so borders and row wraps come early; component
    // extremes, mid-scale, flush after pixels and flush straight after a flush.
    set_width(13'd4);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'hFF, 8'h00, 8'h00);
    push_pixel(8'h00, 8'hFF, 8'h00);
    push_pixel(8'h00, 8'h00, 8'hFF);
    push_pixel(8'h80, 8'h80, 8'h80);
    push_pixel(8'h7F, 8'h80, 8'h81);
    push_pixel(8'hFF, 8'hFF, 8'h00);
    push_flush();
    push_pixel(8'h01, 8'hFE, 8'h80);
    push_pixel(8'h80, 8'h00, 8'hFF);
    push_pixel(8'hFF, 8'h80, 8'h00);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_flush();
    push_flush();
    push_pixel(8'hAA, 8'h55, 8'hAA);
    push_pixel(8'h55, 8'hAA, 8'h55);
    push_pixel(8'h80, 8'h80, 8'h80);
    push_pixel(8'h80, 8'h80, 8'h80);
    push_flush();

    // Random phases: each pairs an idle pattern with a width setting. Width 3
    // after a long row lowers the width mid-row; 0 and 8191 clamp to 1 and 4096.
    run_phase(59, 0, 13'd1, 28);
    run_phase(0, 59, 13'd8191, 40);
    run_phase(6, 6, 13'd3, 28);
    run_phase(0, 0, 13'd0, 20);
    run_phase(0, 59, 13'd4096, 30);
    run_phase(59, 0, 13'd7, 40);
    run_phase(6, 6, 13'd17, 30);

    settle();
    $display("checked %0d coded beats from %0d pixels and %0d flushes", n_beats, n_pixels,
             n_flushes);
    $display("covered %0d width settings and four idle patterns", n_widths);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest legal run with full stalls.
  initial begin
    #4_000_000;
    $display("timeout: %0d coded beats still owed", beats_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mpbae_pkg.sv
hw/rtl/mpbae_if.sv
hw/rtl/mpbae_ram.sv
hw/rtl/med_predict_binary_arith_encoder_core.sv
dv/tb_top.sv
